[src/mvma_pkg.sv]
// Shared types and constants for the matrix-vector multiply-accumulate unit.
// No dependencies.
package mvma_pkg;

	localparam int LEN_W       = 9;
	localparam int LEN_RESET   = 256;
	localparam int RES_DEPTH   = 4;
	localparam int RES_PTR_W   = 2;
	localparam int RES_CNT_W   = 3;

	localparam logic [1:0] ACT_LOAD    = 2'd0;
	localparam logic [1:0] ACT_MATRIX  = 2'd1;
	localparam logic [1:0] ACT_RESTART = 2'd2;

	typedef struct packed {
		logic [1:0]         action;
		logic [7:0]         element_index;
		logic signed [31:0] element_value;
	} item_t;

	typedef struct packed {
		logic signed [63:0] row_sum;
		logic [15:0]        row_number;
	} result_t;

endpackage

[src/mvma_vec_mem.sv]
// Vector store: single-port-write, single-read synchronous RAM with registered read data.
// Depends on nothing but its parameters.
module mvma_vec_mem #(
	parameter int DEPTH = 256,
	parameter int AW    = 8
) (
	input  logic                 clk,
	input  logic                 wr_en,
	input  logic [AW-1:0]        wr_addr,
	input  logic signed [31:0]   wr_data,
	input  logic                 rd_en,
	input  logic [AW-1:0]        rd_addr,
	output logic signed [31:0]   rd_data
);

	logic signed [31:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

[src/mvma_res_fifo.sv]
// Small result queue between the accumulate stage and the result channel.
// Depends on mvma_pkg.
module mvma_res_fifo (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  mvma_pkg::result_t          push_data,
	input  logic                       pop,
	output logic                       not_empty,
	output mvma_pkg::result_t          head,
	output logic [mvma_pkg::RES_CNT_W-1:0] count
);

	import mvma_pkg::*;

	result_t               entry_q [RES_DEPTH];
	logic [RES_PTR_W-1:0]  wr_ptr_q;
	logic [RES_PTR_W-1:0]  rd_ptr_q;
	logic [RES_CNT_W-1:0]  cnt_q;
	logic                  do_pop;

	assign not_empty = (cnt_q != '0);
	assign head      = entry_q[rd_ptr_q];
	assign count     = cnt_q;
	assign do_pop    = pop & not_empty;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + RES_PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + RES_PTR_W'(1);
			end
			case ({push, do_pop})
				2'b10:   cnt_q <= cnt_q + RES_CNT_W'(1);
				2'b01:   cnt_q <= cnt_q - RES_CNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

[src/matrix_vector_multiply_accumulate_unit.sv]
// Top level: streamed matrix-vector product with a RAM-held vector and a saturating MAC.
// Depends on mvma_pkg, mvma_vec_mem and mvma_res_fifo.
//
// Channel   Direction  Handshake                      Payload
// item      in         item_valid / item_stall        mvma_pkg::item_t
// result    out        result_valid / result_stall    mvma_pkg::result_t
// length    in         length_we (write only)         length_wdata[8:0]
//
// One item per cycle while item_stall is low. After a row's last element transfer its result
// passes through vector RAM read at the transfer, multiply, saturating accumulate into the queue.
// Reset clears position, row count, queue; length resets to min(256, depth); vector RAM is not cleared.
// item_stall comes from registers only: it rises when queued plus in-flight row results
// would fill the four-entry result queue; result_stall never blocks the pipeline directly.
module matrix_vector_multiply_accumulate_unit #(
	parameter int VECTOR_DEPTH = 256
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      item_valid,
	output logic                      item_stall,
	input  mvma_pkg::item_t           item,
	output logic                      result_valid,
	input  logic                      result_stall,
	output mvma_pkg::result_t         result,
	input  logic                      length_we,
	input  logic [mvma_pkg::LEN_W-1:0] length_wdata
);

	import mvma_pkg::*;

	localparam int AW       = (VECTOR_DEPTH > 1) ? $clog2(VECTOR_DEPTH) : 1;
	localparam int LW       = $clog2(VECTOR_DEPTH + 1);
	localparam int CW       = (LW > LEN_W) ? LW : LEN_W;
	localparam int RST_LAST = ((VECTOR_DEPTH < LEN_RESET) ? VECTOR_DEPTH : LEN_RESET) - 1;

	logic                 accept;
	logic                 is_load;
	logic                 is_matrix;
	logic                 is_restart;
	logic                 load_ok;
	logic                 row_end;

	logic [AW-1:0]        col_q;
	logic [AW-1:0]        col_last_q;
	logic [15:0]          row_cnt_q;
	logic [CW-1:0]        len_ext;
	logic [AW-1:0]        col_last_nxt;

	logic                 v_s1;
	logic                 last_s1;
	logic                 first_s1;
	logic [15:0]          rownum_s1;
	logic signed [31:0]   value_s1;
	logic signed [31:0]   vec_s1;

	logic                 v_s2;
	logic                 last_s2;
	logic                 first_s2;
	logic [15:0]          rownum_s2;
	logic signed [63:0]   prod_s2;

	logic signed [63:0]   acc_q;
	logic signed [63:0]   acc_base;
	logic signed [64:0]   sum_wide;
	logic signed [63:0]   sum_sat;

	logic                 push;
	result_t              push_data;
	logic [RES_CNT_W-1:0] res_cnt;
	logic [RES_CNT_W-1:0] pending;

	assign accept     = item_valid & ~item_stall;
	assign is_load    = (item.action == ACT_LOAD);
	assign is_matrix  = (item.action == ACT_MATRIX);
	assign is_restart = (item.action == ACT_RESTART);
	assign load_ok    = (32'(item.element_index) < 32'(VECTOR_DEPTH));
	assign row_end    = (col_q >= col_last_q);

	// effective length: zero acts as one, clamp to the store depth
	always_comb begin
		len_ext = CW'(length_wdata);
		if (len_ext == '0) begin
			col_last_nxt = '0;
		end else if (len_ext > CW'(VECTOR_DEPTH)) begin
			col_last_nxt = AW'(VECTOR_DEPTH - 1);
		end else begin
			col_last_nxt = AW'(len_ext - CW'(1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_last_q <= AW'(RST_LAST);
		end else if (length_we) begin
			col_last_q <= col_last_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q     <= '0;
			row_cnt_q <= '0;
		end else if (accept) begin
			if (is_restart) begin
				col_q     <= '0;
				row_cnt_q <= '0;
			end else if (is_matrix) begin
				if (row_end) begin
					col_q     <= '0;
					row_cnt_q <= row_cnt_q + 16'd1;
				end else begin
					col_q <= col_q + AW'(1);
				end
			end
		end
	end

	mvma_vec_mem #(
		.DEPTH (VECTOR_DEPTH),
		.AW    (AW)
	) u_vec_mem (
		.clk     (clk),
		.wr_en   (accept & is_load & load_ok),
		.wr_addr (AW'(item.element_index)),
		.wr_data (item.element_value),
		.rd_en   (accept & is_matrix),
		.rd_addr (col_q),
		.rd_data (vec_s1)
	);

	// stage 1: vector element read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= accept & is_matrix;
		end
	end

	always_ff @(posedge clk) begin
		if (accept & is_matrix) begin
			last_s1   <= row_end;
			first_s1  <= (col_q == '0);
			rownum_s1 <= row_cnt_q;
			value_s1  <= item.element_value;
		end
	end

	// stage 2: product
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			last_s2   <= last_s1;
			first_s2  <= first_s1;
			rownum_s2 <= rownum_s1;
			prod_s2   <= value_s1 * vec_s1;
		end
	end

	// saturating accumulate
	always_comb begin
		acc_base = first_s2 ? 64'sd0 : acc_q;
		sum_wide = {acc_base[63], acc_base} + {prod_s2[63], prod_s2};
		if (sum_wide[64] != sum_wide[63]) begin
			sum_sat = sum_wide[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
		end else begin
			sum_sat = sum_wide[63:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (v_s2) begin
			acc_q <= sum_sat;
		end
	end

	assign push                 = v_s2 & last_s2;
	assign push_data.row_sum    = sum_sat;
	assign push_data.row_number = rownum_s2;

	mvma_res_fifo u_res_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (~result_stall),
		.not_empty (result_valid),
		.head      (result),
		.count     (res_cnt)
	);

	assign pending    = res_cnt + RES_CNT_W'(v_s1 & last_s1) + RES_CNT_W'(v_s2 & last_s2);
	assign item_stall = (pending >= RES_CNT_W'(RES_DEPTH));

endmodule
